// File: sv/mshv_pkg.sv
// shared types and constants for the multi-sensor heater vote
package mshv_pkg;

  // fixed field widths
  localparam int TEMP_W     = 16;
  localparam int IDX_IN_W   = 4;
  localparam int ACT_W      = 5;
  localparam int COUNT_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // a sensor votes once it holds this many samples
  localparam int MIN_VALID = 3;

  // register reset values
  localparam logic signed [TEMP_W-1:0] TARGET_RESET = 16'sd2000;
  localparam logic [ACT_W-1:0]         ACTIVE_RESET = 5'd1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_TEMP    = 2'd0,
    REG_ACTIVE_SENSORS = 2'd1
  } cfg_reg_t;

  // vote result handed from the vote logic to the output register
  typedef struct packed {
    logic               any_valid;
    logic               heater_on;
    logic [COUNT_W-1:0] valid_count;
    logic [COUNT_W-1:0] below_count;
  } vote_t;

endpackage

// File: sv/mshv_in_if.sv
// reading channel: sensor index and temperature
interface mshv_in_if import mshv_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [IDX_IN_W-1:0]      sensor_index;
  logic signed [TEMP_W-1:0] temperature;

  modport source (output valid, output sensor_index, output temperature, input ready);
  modport sink   (input valid, input sensor_index, input temperature, output ready);
endinterface

// File: sv/mshv_out_if.sv
// result channel: heater command and vote counts
interface mshv_out_if import mshv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               heater_on;
  logic [COUNT_W-1:0] valid_count;
  logic [COUNT_W-1:0] below_count;

  modport source (output valid, output heater_on, output valid_count, output below_count,
                  input ready);
  modport sink   (input valid, input heater_on, input valid_count, input below_count,
                  output ready);
endinterface

// File: sv/mshv_cfg_if.sv
// configuration write channel: register index and write data
interface mshv_cfg_if import mshv_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/mshv_ram.sv
// generic single-port-write ram with registered read
module mshv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/mshv_window.sv
// per-sensor sample windows: ring buffer in ram, fill counts and running sums
module mshv_window import mshv_pkg::*; #(
  parameter int SENSOR_SLOTS = 16,
  parameter int WINDOW_LEN   = 5
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       adv,
  input  logic                                       accept,
  input  logic [IDX_IN_W-1:0]                        in_idx,
  input  logic signed [TEMP_W-1:0]                   in_temp,
  input  logic [ACT_W-1:0]                           active_sensors,
  output logic [$clog2(WINDOW_LEN+1)-1:0]            fill [SENSOR_SLOTS],
  output logic signed [TEMP_W+$clog2(WINDOW_LEN)-1:0] sum [SENSOR_SLOTS]
);

  localparam int IDX_W  = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;
  localparam int PTR_W  = $clog2(WINDOW_LEN);
  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W  = TEMP_W + $clog2(WINDOW_LEN);
  localparam int ADDR_W = IDX_W + PTR_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam logic [FILL_W-1:0] FILL_MAX    = FILL_W'(WINDOW_LEN);
  localparam logic [PTR_W-1:0]  PTR_LAST    = PTR_W'(WINDOW_LEN - 1);
  localparam logic [7:0]        SLOTS_LIMIT = 8'(SENSOR_SLOTS);

  logic [7:0]              idx_ext;
  logic [IDX_W-1:0]        sidx;
  logic                    push_in;
  logic [PTR_W-1:0]        ptr [SENSOR_SLOTS];
  logic [PTR_W-1:0]        ptr_cur;
  logic [FILL_W-1:0]       fill_cur;
  logic                    full_in;
  logic [FILL_W-1:0]       fill_new;

  // update stage registers
  logic                     a_push;
  logic [IDX_W-1:0]         a_idx;
  logic signed [TEMP_W-1:0] a_temp;
  logic [ADDR_W-1:0]        a_addr;
  logic                     a_full;
  logic [FILL_W-1:0]        a_fill;

  logic [TEMP_W-1:0]        old_sample;
  logic signed [SUM_W-1:0]  temp_ext;
  logic signed [SUM_W-1:0]  old_ext;
  logic signed [SUM_W-1:0]  sum_next;

  // slot select and drop check
  assign idx_ext = {{(8 - IDX_IN_W){1'b0}}, in_idx};
  assign sidx    = idx_ext[IDX_W-1:0];
  assign push_in = accept && ({1'b0, in_idx} < active_sensors) && (idx_ext < SLOTS_LIMIT);
  assign ptr_cur = ptr[sidx];

  // fill count as it stands once the item in the update stage commits
  assign fill_cur = (a_push && (a_idx == sidx)) ? a_fill : fill[sidx];
  assign full_in  = (fill_cur == FILL_MAX);
  assign fill_new = full_in ? FILL_MAX : fill_cur + 1'b1;

  // oldest sample leaves the sum only once the window is full
  assign temp_ext = {{(SUM_W - TEMP_W){a_temp[TEMP_W-1]}}, a_temp};
  assign old_ext  = a_full ? {{(SUM_W - TEMP_W){old_sample[TEMP_W-1]}}, old_sample} : '0;
  assign sum_next = sum[a_idx] + temp_ext - old_ext;

  // sample ring: read oldest on accept, write newest in the update stage
  mshv_ram #(
    .WIDTH (TEMP_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (adv && a_push),
    .waddr (a_addr),
    .wdata (a_temp),
    .re    (push_in),
    .raddr ({sidx, ptr_cur}),
    .rdata (old_sample)
  );

  // control state: pointers, fill counts, sums
  always_ff @(posedge clk) begin
    if (rst) begin
      a_push <= 1'b0;
      for (int s = 0; s < SENSOR_SLOTS; s++) begin
        ptr[s]  <= '0;
        fill[s] <= '0;
        sum[s]  <= '0;
      end
    end else if (adv) begin
      a_push <= push_in;
      if (push_in) begin
        ptr[sidx] <= (ptr_cur == PTR_LAST) ? '0 : ptr_cur + 1'b1;
      end
      if (a_push) begin
        fill[a_idx] <= a_fill;
        sum[a_idx]  <= sum_next;
      end
    end
  end

  // item payload into the update stage
  always_ff @(posedge clk) begin
    if (adv && push_in) begin
      a_idx  <= sidx;
      a_temp <= in_temp;
      a_addr <= {sidx, ptr_cur};
      a_full <= full_in;
      a_fill <= fill_new;
    end
  end

endmodule

// File: sv/mshv_vote.sv
// per-sensor below-target compare and majority vote
module mshv_vote import mshv_pkg::*; #(
  parameter int SENSOR_SLOTS = 16,
  parameter int WINDOW_LEN   = 5
) (
  input  logic                                        clk,
  input  logic signed [TEMP_W-1:0]                    target_temp,
  input  logic [ACT_W-1:0]                            active_sensors,
  input  logic [$clog2(WINDOW_LEN+1)-1:0]             fill [SENSOR_SLOTS],
  input  logic signed [TEMP_W+$clog2(WINDOW_LEN)-1:0] sum [SENSOR_SLOTS],
  output vote_t                                       vote
);

  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W  = TEMP_W + $clog2(WINDOW_LEN);
  localparam int PROD_W = TEMP_W + FILL_W + 1;
  localparam int CNT_W  = $clog2(SENSOR_SLOTS + 1);
  localparam logic [FILL_W-1:0] FILL_MIN = FILL_W'(MIN_VALID);

  logic signed [PROD_W-1:0] target_ext;
  logic signed [PROD_W-1:0] prod [WINDOW_LEN+1];
  logic [SENSOR_SLOTS-1:0]  valid_vec;
  logic [SENSOR_SLOTS-1:0]  below_vec;
  logic [CNT_W-1:0]         valid_cnt;
  logic [CNT_W-1:0]         below_cnt;
  logic [7:0]               valid_wide;
  logic [7:0]               below_wide;

  assign target_ext = {{(PROD_W - TEMP_W){target_temp[TEMP_W-1]}}, target_temp};

  // target times each possible fill count, refreshed after a target write
  always_ff @(posedge clk) begin
    for (int n = 0; n <= WINDOW_LEN; n++) begin
      prod[n] <= target_ext * PROD_W'(n);
    end
  end

  // per-sensor valid and below flags
  for (genvar s = 0; s < SENSOR_SLOTS; s++) begin : g_sensor
    logic signed [PROD_W-1:0] sum_ext;
    assign sum_ext      = {{(PROD_W - SUM_W){sum[s][SUM_W-1]}}, sum[s]};
    assign valid_vec[s] = (fill[s] >= FILL_MIN) && ({2'b00, active_sensors} > 7'(s));
    assign below_vec[s] = valid_vec[s] && (sum_ext < prod[fill[s]]);
  end

  // counts and majority
  assign valid_cnt  = CNT_W'($countones(valid_vec));
  assign below_cnt  = CNT_W'($countones(below_vec));
  assign valid_wide = 8'(valid_cnt);
  assign below_wide = 8'(below_cnt);

  assign vote.any_valid   = (valid_cnt != '0);
  assign vote.heater_on   = (below_cnt > (valid_cnt >> 1));
  assign vote.valid_count = valid_wide[COUNT_W-1:0];
  assign vote.below_count = below_wide[COUNT_W-1:0];

endmodule

// File: sv/multi_sensor_heater_vote.sv
// top level of the multi-sensor heater vote
//
// channels: "in" takes one item per reading (sensor_index, temperature);
// "out" gives heater_on with valid_count and below_count; "cfg" writes
// target_temp (index 0) and active_sensors (index 1), always ready.
// a reading whose index is at or beyond the active count changes nothing,
// but the vote is still taken and reported.
// an accepted item moves through the registers a_valid, b_valid and
// out_valid; it gives its result on "out" only if some sensor is valid;
// an item with no valid sensor gives no result.
// throughput: one item per cycle while "out" is not stalled; the sample
// ring is one ram with one write and one read per cycle, so same-sensor
// readings may follow each other without a gap.
// stall: when a result waits on "out" and ready is low, the whole
// pipeline holds and in.ready drops; it rises again as soon as the
// result is taken.
// reset: clears fill counts, sums, ring pointers and pipeline state,
// and loads target_temp 2000 and active_sensors 1; the ram needs no
// clearing since the oldest sample leaves a sum only once the window is full.
module multi_sensor_heater_vote import mshv_pkg::*; #(
  parameter int SENSOR_SLOTS = 16,
  parameter int WINDOW_LEN   = 5
) (
  input  logic       clk,
  input  logic       rst,
  mshv_in_if.sink    in,
  mshv_out_if.source out,
  mshv_cfg_if.sink   cfg
);

  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W  = TEMP_W + $clog2(WINDOW_LEN);

  logic signed [TEMP_W-1:0] target_temp;
  logic [ACT_W-1:0]         active_sensors;

  logic                     adv;
  logic                     accept;
  logic                     a_valid;
  logic                     b_valid;
  logic                     out_valid;
  vote_t                    vote;

  logic [FILL_W-1:0]        fill [SENSOR_SLOTS];
  logic signed [SUM_W-1:0]  sum [SENSOR_SLOTS];

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_temp    <= TARGET_RESET;
      active_sensors <= ACTIVE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_TARGET_TEMP:    target_temp    <= cfg.data;
        REG_ACTIVE_SENSORS: active_sensors <= cfg.data[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline moves whenever the output register is free or being emptied
  assign adv      = !out_valid || out.ready;
  assign in.ready = adv;
  assign accept   = in.valid && adv;

  // window storage and running sums
  mshv_window #(
    .SENSOR_SLOTS (SENSOR_SLOTS),
    .WINDOW_LEN   (WINDOW_LEN)
  ) u_window (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .accept         (accept),
    .in_idx         (in.sensor_index),
    .in_temp        (in.temperature),
    .active_sensors (active_sensors),
    .fill           (fill),
    .sum            (sum)
  );

  // vote over the committed state
  mshv_vote #(
    .SENSOR_SLOTS (SENSOR_SLOTS),
    .WINDOW_LEN   (WINDOW_LEN)
  ) u_vote (
    .clk            (clk),
    .target_temp    (target_temp),
    .active_sensors (active_sensors),
    .fill           (fill),
    .sum            (sum),
    .vote           (vote)
  );

  // stage valids and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      a_valid   <= accept;
      b_valid   <= a_valid;
      out_valid <= b_valid && vote.any_valid;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (adv && b_valid) begin
      out.heater_on   <= vote.heater_on;
      out.valid_count <= vote.valid_count;
      out.below_count <= vote.below_count;
    end
  end

  assign out.valid = out_valid;

endmodule

// File: test/mshv_vote_checker.sv
// checker: predicts heater vote results and compares them on the result channel
module mshv_vote_checker import mshv_pkg::*; #(
  parameter int SENSOR_SLOTS = 16,
  parameter int WINDOW_LEN   = 5
) (
  input  logic clk,
  input  logic rst,
  mshv_in_if   rd_ch,
  mshv_out_if  cmd_ch,
  mshv_cfg_if  cfg_ch,
  output int   errors,
  output int   outstanding
);

  localparam int PRINT_CAP = 50;

  // one heater command as seen on the result channel
  typedef struct packed {
    logic               heater_on;
    logic [COUNT_W-1:0] valid_count;
    logic [COUNT_W-1:0] below_count;
  } heater_cmd_t;

  // predictor state: per-sensor sample history, fill level and running total
  logic signed [TEMP_W-1:0] history [SENSOR_SLOTS][WINDOW_LEN];
  int unsigned              held [SENSOR_SLOTS];
  int                       win_total [SENSOR_SLOTS];
  logic signed [TEMP_W-1:0] goal_temp;
  logic [ACT_W-1:0]         vote_members;
  heater_cmd_t              cmd_q [$];

  // print one mismatch line and count it
  task automatic report_mismatch(string what);
    if (errors < PRINT_CAP) begin
      $display("mismatch at %0t: %s", $time, what);
    end
    errors++;
  endtask

  // clear history and load register defaults
  task automatic clear_model();
    for (int s = 0; s < SENSOR_SLOTS; s++) begin
      for (int k = 0; k < WINDOW_LEN; k++) begin
        history[s][k] = '0;
      end
      held[s] = 0;
      win_total[s] = 0;
    end
    goal_temp = TARGET_RESET;
    vote_members = ACTIVE_RESET;
    cmd_q.delete();
  endtask

  // fold one reading into the history, then take the vote
  task automatic take_reading(input logic [IDX_IN_W-1:0] idx,
                              input logic signed [TEMP_W-1:0] temp);
    int unsigned members;
    int unsigned n_valid;
    int unsigned n_below;
    int          k;
    heater_cmd_t cmd;
    members = (vote_members > SENSOR_SLOTS) ? SENSOR_SLOTS : vote_members;
    n_valid = 0;
    n_below = 0;
    // readings from sensors outside the vote leave the history alone
    if (idx < members) begin
      win_total[idx] += int'(temp) - int'(history[idx][WINDOW_LEN-1]);
      for (k = WINDOW_LEN - 1; k > 0; k--) begin
        history[idx][k] = history[idx][k-1];
      end
      history[idx][0] = temp;
      if (held[idx] < WINDOW_LEN) begin
        held[idx]++;
      end
    end
    // mean below target tested as total < target * fill, no division
    for (k = 0; k < members; k++) begin
      if (held[k] >= MIN_VALID) begin
        n_valid++;
        if (longint'(win_total[k]) < longint'(goal_temp) * longint'(held[k])) begin
          n_below++;
        end
      end
    end
    // nothing is reported until some sensor is valid
    if (n_valid != 0) begin
      cmd.heater_on   = (n_below > n_valid / 2);
      cmd.valid_count = COUNT_W'(n_valid);
      cmd.below_count = COUNT_W'(n_below);
      cmd_q.push_back(cmd);
    end
  endtask

  // watch all three channels at each edge
  always @(posedge clk) begin
    heater_cmd_t want;
    if (rst) begin
      clear_model();
    end else begin
      // compare a delivered command with the oldest prediction
      if (cmd_ch.valid && cmd_ch.ready) begin
        if (cmd_q.size() == 0) begin
          report_mismatch($sformatf("unexpected item heater_on=%0d valid=%0d below=%0d",
                                    cmd_ch.heater_on, cmd_ch.valid_count,
                                    cmd_ch.below_count));
        end else begin
          want = cmd_q.pop_front();
          if (cmd_ch.heater_on !== want.heater_on) begin
            report_mismatch($sformatf("heater_on got %0d want %0d",
                                      cmd_ch.heater_on, want.heater_on));
          end
          if (cmd_ch.valid_count !== want.valid_count) begin
            report_mismatch($sformatf("valid_count got %0d want %0d",
                                      cmd_ch.valid_count, want.valid_count));
          end
          if (cmd_ch.below_count !== want.below_count) begin
            report_mismatch($sformatf("below_count got %0d want %0d",
                                      cmd_ch.below_count, want.below_count));
          end
        end
      end
      // register writes
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_TARGET_TEMP: begin
            goal_temp = cfg_ch.data;
          end
          REG_ACTIVE_SENSORS: begin
            vote_members = cfg_ch.data[ACT_W-1:0];
          end
          default: ;
        endcase
      end
      // accepted reading
      if (rd_ch.valid && rd_ch.ready) begin
        take_reading(rd_ch.sensor_index, rd_ch.temperature);
      end
    end
    outstanding <= cmd_q.size();
  end

endmodule

// File: test/tb_multi_sensor_heater_vote.sv
// testbench top: stimulus, handshakes and verdict for the heater vote
module tb_multi_sensor_heater_vote import mshv_pkg::*; ();

  localparam int DRAIN_CYCLES  = 8;
  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 130;

  logic clk = 1'b0;
  logic rst;
  int   check_errors;
  int   results_owed;
  int   idle_cycles;
  int   rx_hold;
  bit   rx_stalls_on;
  bit   tx_gaps_on;
  int   sensor_bias [16];

  mshv_in_if  rd_ch ();
  mshv_out_if cmd_ch ();
  mshv_cfg_if cfg_ch ();

  multi_sensor_heater_vote dut (
    .clk (clk),
    .rst (rst),
    .in  (rd_ch),
    .out (cmd_ch),
    .cfg (cfg_ch)
  );

  mshv_vote_checker vote_chk (
    .clk         (clk),
    .rst         (rst),
    .rd_ch       (rd_ch),
    .cmd_ch      (cmd_ch),
    .cfg_ch      (cfg_ch),
    .errors      (check_errors),
    .outstanding (results_owed)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // gap length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 12);
    else return $urandom_range(20, 40);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      cmd_ch.ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (rx_stalls_on && $urandom_range(0, 99) < 20) begin
      cmd_ch.ready <= 1'b0;
      rx_hold <= pick_gap() - 1;
    end else begin
      cmd_ch.ready <= 1'b1;
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (rd_ch.valid && rd_ch.ready) || (cmd_ch.valid && cmd_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // offer one reading, optionally after a gap, and hold it until taken
  task automatic send_reading(input logic [IDX_IN_W-1:0] idx, input logic [TEMP_W-1:0] temp);
    int gap;
    gap = (tx_gaps_on && $urandom_range(0, 99) < 25) ? pick_gap() : 0;
    if (gap > 0) begin
      rd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rd_ch.valid        <= 1'b1;
    rd_ch.sensor_index <= idx;
    rd_ch.temperature  <= temp;
    do @(posedge clk); while (!rd_ch.ready);
  endtask

  // stop sending and wait until every predicted command has been delivered
  task automatic settle();
    rd_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one register write while the block is idle
  task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= which;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // random reading: mostly voting sensors near target with a per-sensor lean
  task automatic send_random(input int tgt, input int act);
    int                  members;
    int                  r;
    int                  t;
    logic [IDX_IN_W-1:0] idx;
    members = (act > 16) ? 16 : act;
    if (members > 0 && $urandom_range(0, 99) < 85) begin
      idx = IDX_IN_W'($urandom_range(0, members - 1));
    end else begin
      idx = IDX_IN_W'($urandom_range(0, 15));
    end
    r = $urandom_range(0, 99);
    if (r < 70) t = tgt + sensor_bias[idx] + int'($urandom_range(0, 400)) - 200;
    else if (r < 88) t = int'($urandom_range(0, 65535)) - 32768;
    else if (r < 94) t = -32768;
    else t = 32767;
    if (t > 32767) t = 32767;
    else if (t < -32768) t = -32768;
    send_reading(idx, TEMP_W'(t));
  endtask

  // stimulus
  initial begin
    int tgt;
    int act;
    int count;
    rst                = 1'b1;
    rd_ch.valid        = 1'b0;
    rd_ch.sensor_index = '0;
    rd_ch.temperature  = '0;
    cmd_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_TARGET_TEMP;
    cfg_ch.data        = '0;
    rx_hold            = 0;
    rx_stalls_on       = 1'b0;
    tx_gaps_on         = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // defaults: one sensor, target 2000; filling up, tie, below, extremes
    send_reading(4'd0, 16'sd2000);
    send_reading(4'd0, 16'sd1999);
    send_reading(4'd15, 16'sd0);
    send_reading(4'd0, 16'sd2001);
    send_reading(4'd0, 16'sd1990);
    send_reading(4'd0, 16'sh7fff);
    send_reading(4'd0, 16'sh8000);
    send_reading(4'd0, 16'sh8000);
    send_reading(4'd1, 16'sd500);
    send_reading(4'd0, -16'sd1000);

    // lowest target, all sensors: equal totals are not below
    settle();
    write_reg(REG_TARGET_TEMP, 16'h8000);
    write_reg(REG_ACTIVE_SENSORS, 16'd16);
    send_reading(4'd2, 16'sh8000);
    send_reading(4'd2, 16'sh8000);
    send_reading(4'd2, 16'sh8000);
    send_reading(4'd3, -16'sd1000);
    send_reading(4'd3, -16'sd5000);
    send_reading(4'd3, -16'sd1001);

    // highest target, active count past the slot count
    settle();
    write_reg(REG_TARGET_TEMP, 16'h7fff);
    write_reg(REG_ACTIVE_SENSORS, 16'd17);
    send_reading(4'd15, 16'sh7fff);
    send_reading(4'd15, 16'sh7fff);
    send_reading(4'd15, 16'sh7fff);

    // no sensor in the vote: every reading dropped, nothing reported
    settle();
    write_reg(REG_ACTIVE_SENSORS, 16'd0);
    send_reading(4'd0, 16'sd1000);
    send_reading(4'd9, -16'sd1);

    // random phases over several register settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      count = PHASE_ITEMS;
      tgt = int'($urandom_range(0, 65535)) - 32768;
      act = $urandom_range(1, 16);
      case (p)
        0: begin
          tgt = 2000;
          act = 16;
        end
        1: begin
          tgt = 0;
          act = 3;
        end
        2: begin
          tgt = -32768;
          act = 16;
        end
        3: begin
          tgt = 32767;
          act = 8;
        end
        4: act = 31;
        5: begin
          act = 0;
          count = 60;
        end
        6: act = 1;
        9: begin
          tgt = 2000;
          act = 16;
        end
        default: ;
      endcase
      settle();
      write_reg(REG_TARGET_TEMP, CFG_DATA_W'(tgt));
      write_reg(REG_ACTIVE_SENSORS, CFG_DATA_W'(act));
      for (int s = 0; s < 16; s++) begin
        sensor_bias[s] = int'($urandom_range(0, 800)) - 400;
      end
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_stalls_on <= ($urandom_range(0, 3) != 0);
      for (int i = 0; i < count; i++) begin
        // occasional full drain in the middle of a phase
        if ($urandom_range(0, 199) == 0) settle();
        send_random(tgt, act);
      end
    end

    // drain and verdict
    settle();
    if (check_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/mshv_pkg.sv
sv/mshv_in_if.sv
sv/mshv_out_if.sv
sv/mshv_cfg_if.sv
sv/mshv_ram.sv
sv/mshv_window.sv
sv/mshv_vote.sv
sv/multi_sensor_heater_vote.sv
test/mshv_vote_checker.sv
test/tb_multi_sensor_heater_vote.sv
